[src/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay package
// Shared constants, configuration record and saturation helpers.
// ----------------------------------------------------------------------------
package mfd_pkg;

   // Default sizes of the delay ring and the sine quantizer.
   localparam int unsigned DEF_RING_FRAMES     = 4096;
   localparam int unsigned DEF_MAX_CHANNELS    = 2;
   localparam int unsigned DEF_SINE_TABLE_BITS = 10;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_DRY_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_DELAY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MOD_DEPTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LFO_STEP   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNELS   = 3'd6;

   // Sample and accumulator widths.
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned ACC_W    = 24;

   // Quarter-wave sine polynomial coefficients, Q15.
   localparam int unsigned SIN_A = 51472;
   localparam int unsigned SIN_B = 21024;
   localparam int unsigned SIN_C = 2320;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [15:0] dry_gain;
      logic [15:0] wet_gain;
      logic [15:0] feedback_gain;
      logic [19:0] base_delay;
      logic [19:0] mod_depth;
      logic [31:0] lfo_step;
      logic [3:0]  active_channels;
   } cfg_type;

   // Saturate to the signed range of a ring word.
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [31:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > 32'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -32'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   // Saturate to the signed range of an output sample.
   function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [31:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/mfd_front.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay front end
// Accepts requests, tracks channel, frame and LFO phase, and tags each
// sample with the position it belongs to.
// ----------------------------------------------------------------------------
module mfd_front #(
   parameter int unsigned RING_FRAMES  = mfd_pkg::DEF_RING_FRAMES,
   parameter int unsigned MAX_CHANNELS = mfd_pkg::DEF_MAX_CHANNELS,
   parameter int unsigned ITEM_W       = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mfd_pkg::cfg_type                  cfg,
   input  logic                              clear_done,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mfd_pkg::SAMPLE_W-1:0]      req_tdata,
   input  logic                              queue_ready,
   output logic                              queue_push,
   output logic [ITEM_W-1:0]                 queue_item
);
   import mfd_pkg::*;

   localparam int unsigned FRAME_W = $clog2(RING_FRAMES);
   localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [31:0]        phase_ff, phase_in;

   logic [3:0]         chans;
   logic               wrap_first;
   logic [CH_W-1:0]    cur_ch;
   logic [FRAME_W-1:0] cur_frame;
   logic [31:0]        cur_phase;
   logic [3:0]         next_ch;
   logic               new_frame;

   function automatic logic [FRAME_W-1:0] frame_inc(input logic [FRAME_W-1:0] f);
      logic [FRAME_W-1:0] r;
      if (f == FRAME_W'(RING_FRAMES - 1)) begin
         r = '0;
      end else begin
         r = f + 1'b1;
      end
      return r;
   endfunction

   // Effective channel count.
   always_comb begin
      if (cfg.active_channels == 4'd0) begin
         chans = 4'd1;
      end else if (cfg.active_channels > 4'(MAX_CHANNELS)) begin
         chans = 4'(MAX_CHANNELS);
      end else begin
         chans = cfg.active_channels;
      end
   end

   // Close a frame left open by a lowered channel count, then tag the sample.
   always_comb begin
      wrap_first = 4'(ch_ff) >= chans;
      cur_ch     = wrap_first ? '0 : ch_ff;
      cur_frame  = wrap_first ? frame_inc(frame_ff) : frame_ff;
      cur_phase  = wrap_first ? phase_ff + cfg.lfo_step : phase_ff;
      new_frame  = (cur_ch == '0);
      next_ch    = 4'(cur_ch) + 4'd1;
      if (next_ch >= chans) begin
         ch_in    = '0;
         frame_in = frame_inc(cur_frame);
         phase_in = cur_phase + cfg.lfo_step;
      end else begin
         ch_in    = CH_W'(next_ch);
         frame_in = cur_frame;
         phase_in = cur_phase;
      end
   end

   assign req_tready = clear_done && queue_ready;
   assign queue_push = req_tvalid && req_tready;
   assign queue_item = {cur_phase, new_frame, cur_frame, cur_ch, req_tdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= '0;
         frame_ff <= '0;
         phase_ff <= '0;
      end else if (queue_push) begin
         ch_ff    <= ch_in;
         frame_ff <= frame_in;
         phase_ff <= phase_in;
      end
   end

endmodule

[src/mfd_queue.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay queue
// Short first-in first-out queue that decouples front and back.
// ----------------------------------------------------------------------------
module mfd_queue #(
   parameter int unsigned ITEM_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [ITEM_W-1:0] push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [ITEM_W-1:0] pop_item
);
   import mfd_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ITEM_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

[src/mfd_back.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay back end
// Computes the LFO taps once per frame, runs the ring read-modify-write
// sequence for each sample and holds the output register.
// ----------------------------------------------------------------------------
module mfd_back #(
   parameter int unsigned RING_FRAMES     = mfd_pkg::DEF_RING_FRAMES,
   parameter int unsigned MAX_CHANNELS    = mfd_pkg::DEF_MAX_CHANNELS,
   parameter int unsigned SINE_TABLE_BITS = mfd_pkg::DEF_SINE_TABLE_BITS,
   parameter int unsigned ITEM_W          = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mfd_pkg::cfg_type             cfg,
   output logic                         clear_done,
   input  logic                         item_valid,
   input  logic [ITEM_W-1:0]            item,
   output logic                         item_pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mfd_pkg::SAMPLE_W-1:0] rsp_tdata
);
   import mfd_pkg::*;

   localparam int unsigned FRAME_W   = $clog2(RING_FRAMES);
   localparam int unsigned CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned MEM_WORDS = RING_FRAMES * MAX_CHANNELS;
   localparam int unsigned ADDR_W    = $clog2(MEM_WORDS);
   localparam int unsigned WHOLE_W   = 13;
   localparam int unsigned RED_W     = 30;
   localparam int unsigned STB       = SINE_TABLE_BITS;
   // Reciprocal of the ring length, exact for every whole part below 2^WHOLE_W.
   localparam int unsigned RED_SH    = WHOLE_W + $clog2(RING_FRAMES);
   localparam longint unsigned RED_RECIP =
      ((64'd1 << RED_SH) + 64'(RING_FRAMES) - 64'd1) / 64'(RING_FRAMES);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_X2, ST_T1, ST_T2, ST_S, ST_S2, ST_S3, ST_MOD, ST_RED,
      ST_ADDR, ST_RD0, ST_RD1, ST_RDC, ST_TAP, ST_MUL, ST_MIX, ST_FB, ST_W1, ST_WC
   } state_type;

   state_type state_ff, state_in;

   // Ring memory.
   logic signed [ACC_W-1:0] delay_mem [MEM_WORDS];
   logic signed [ACC_W-1:0] rd_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   logic signed [ACC_W-1:0] mem_wdata;

   logic [ADDR_W-1:0]       clr_ff, clr_in;

   // Item fields.
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic [FRAME_W-1:0]         frame_ff, frame_in;
   logic [31:0]                phase_ff, phase_in;

   // Tap computation.
   logic [19:0]          mul_a;
   logic [17:0]          mul_b;
   logic [37:0]          prod;
   logic [17:0]          x2_ff, x2_in;
   logic [16:0]          t_ff, t_in;
   logic [17:0]          s_ff, s_in;
   logic [16:0]          u_ff, u_in;
   logic [WHOLE_W-1:0]   red_ff, red_in;
   logic [7:0]           frac_ff, frac_in;
   logic [STB-1:0]       k;
   logic [1:0]           quad;
   logic [15:0]          xr, xs;
   logic [17:0]          s3;
   logic [20:0]          dsum;
   logic [RED_W-1:0]     red_prod;
   logic [WHOLE_W-1:0]   red_quo;

   // Addresses and sample path.
   logic [FRAME_W:0]          fa_sum;
   logic [FRAME_W-1:0]        fa, fb;
   logic [ADDR_W-1:0]         a0_ff, a0_in, a1_ff, a1_in, ac_ff, ac_in;
   logic [8:0]                w0;
   logic signed [25:0]        p0, p1;
   logic signed [17:0]        i0_ff, i0_in, i1_ff, i1_in;
   logic signed [ACC_W-1:0]   v0_ff, v0_in, v1_ff, v1_in;
   logic signed [ACC_W-1:0]   tap_ff, tap_in;
   logic signed [32:0]        pd_ff, pd_in;
   logic signed [40:0]        pw_ff, pw_in, pf_ff, pf_in;
   logic signed [50:0]        f0_ff, f0_in, f1_ff, f1_in;
   logic signed [41:0]        y_sum;
   logic                      out_free;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [FRAME_W-1:0] f,
                                                   input logic [CH_W-1:0] c);
      return ADDR_W'(32'(f) * 32'(MAX_CHANNELS) + 32'(c));
   endfunction

   // Quantized phase, folded into the first quadrant.
   always_comb begin
      k    = phase_ff[31 -: STB];
      quad = k[STB-1 -: 2];
      xr   = 16'(k[STB-3:0]) << (15 - (STB - 2));
      xs   = quad[0] ? 16'(17'd32768 - 17'(xr)) : xr;
   end

   // Shared multiplier for the tap computation.
   always_comb begin
      case (state_ff)
         ST_X2:   begin mul_a = 20'(xs);       mul_b = 18'(xs);   end
         ST_T1:   begin mul_a = 20'(SIN_C);    mul_b = x2_ff;     end
         ST_T2:   begin mul_a = 20'(x2_ff);    mul_b = 18'(t_ff); end
         ST_S:    begin mul_a = 20'(xs);       mul_b = 18'(t_ff); end
         ST_S2:   begin mul_a = 20'(s_ff);     mul_b = s_ff;      end
         ST_S3:   begin mul_a = 20'(x2_ff);    mul_b = s_ff;      end
         ST_MOD:  begin mul_a = cfg.mod_depth; mul_b = 18'(u_ff); end
         default: begin mul_a = '0;            mul_b = '0;        end
      endcase
      prod     = 38'(mul_a) * 38'(mul_b);
      s3       = 18'(prod >> 15);
      dsum     = 21'(cfg.base_delay) + 21'(prod >> 16);
      red_prod = RED_W'(red_ff) * RED_W'(RED_RECIP);
      red_quo  = WHOLE_W'(red_prod >> RED_SH);
   end

   // Sample path arithmetic.
   always_comb begin
      fa_sum = (FRAME_W+1)'(frame_ff) + (FRAME_W+1)'(red_ff);
      fa     = (fa_sum >= (FRAME_W+1)'(RING_FRAMES)) ?
               FRAME_W'(fa_sum - (FRAME_W+1)'(RING_FRAMES)) : FRAME_W'(fa_sum);
      fb     = (fa == FRAME_W'(RING_FRAMES - 1)) ? '0 : fa + 1'b1;
      w0     = 9'd256 - 9'(frac_ff);
      p0     = 26'(x_ff) * 26'($signed({1'b0, w0}));
      p1     = 26'(x_ff) * 26'($signed({2'b0, frac_ff}));
      y_sum  = 42'(pd_ff) + 42'(pw_ff);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      ch_in        = ch_ff;
      frame_in     = frame_ff;
      phase_in     = phase_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      u_in         = u_ff;
      red_in       = red_ff;
      frac_in      = frac_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      ac_in        = ac_ff;
      i0_in        = i0_ff;
      i1_in        = i1_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      tap_in       = tap_ff;
      pd_in        = pd_ff;
      pw_in        = pw_ff;
      pf_in        = pf_ff;
      f0_in        = f0_ff;
      f1_in        = f1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = a0_ff;
      mem_wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               x_in     = item[SAMPLE_W-1:0];
               ch_in    = item[SAMPLE_W +: CH_W];
               frame_in = item[SAMPLE_W+CH_W +: FRAME_W];
               phase_in = item[ITEM_W-1 -: 32];
               state_in = item[SAMPLE_W+CH_W+FRAME_W] ? ST_X2 : ST_ADDR;
            end
         end
         ST_X2: begin
            x2_in    = 18'(prod >> 15);
            state_in = ST_T1;
         end
         ST_T1: begin
            t_in     = 17'(SIN_B) - 17'(prod >> 15);
            state_in = ST_T2;
         end
         ST_T2: begin
            t_in     = 17'(SIN_A) - 17'(prod >> 15);
            state_in = ST_S;
         end
         ST_S: begin
            s_in     = 18'(prod >> 15);
            state_in = ST_S2;
         end
         ST_S2: begin
            x2_in    = 18'(prod >> 15);
            state_in = ST_S3;
         end
         ST_S3: begin
            u_in     = quad[1] ? 17'(18'd32768 - s3) : 17'(18'd32768 + s3);
            state_in = ST_MOD;
         end
         ST_MOD: begin
            red_in   = dsum[20:8];
            frac_in  = dsum[7:0];
            state_in = ST_RED;
         end
         ST_RED: begin
            // Whole part modulo the ring length by reciprocal multiplication.
            red_in   = WHOLE_W'(RED_W'(red_ff) - RED_W'(red_quo) * RED_W'(RING_FRAMES));
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            a0_in    = word_addr(fa, ch_ff);
            a1_in    = word_addr(fb, ch_ff);
            ac_in    = word_addr(frame_ff, ch_ff);
            i0_in    = 18'(p0 >>> 8);
            i1_in    = 18'(p1 >>> 8);
            state_in = ST_RD0;
         end
         ST_RD0: begin
            mem_addr = a0_ff;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            mem_addr = a1_ff;
            v0_in    = sat_acc(32'(rd_ff) + 32'(i0_ff));
            state_in = ST_RDC;
         end
         ST_RDC: begin
            mem_addr = ac_ff;
            v1_in    = sat_acc(32'(rd_ff) + 32'(i1_ff));
            state_in = ST_TAP;
         end
         ST_TAP: begin
            // The current word may be one of the taps that just took the input.
            if (ac_ff == a0_ff) begin
               tap_in = v0_ff;
            end else if (ac_ff == a1_ff) begin
               tap_in = v1_ff;
            end else begin
               tap_in = rd_ff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            pd_in    = 33'(x_ff) * 33'($signed({1'b0, cfg.dry_gain}));
            pw_in    = 41'(tap_ff) * 41'($signed({1'b0, cfg.wet_gain}));
            pf_in    = 41'(tap_ff) * 41'($signed({1'b0, cfg.feedback_gain}));
            state_in = ST_MIX;
         end
         ST_MIX: begin
            f0_in = 51'(pf_ff) * 51'($signed({1'b0, w0}));
            f1_in = 51'(pf_ff) * 51'($signed({2'b0, frac_ff}));
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_out(32'(y_sum >>> 14));
               state_in     = ST_FB;
            end
         end
         ST_FB: begin
            mem_we    = 1'b1;
            mem_addr  = a0_ff;
            mem_wdata = sat_acc(32'(v0_ff) + 32'(f0_ff >>> 22));
            state_in  = ST_W1;
         end
         ST_W1: begin
            mem_we    = 1'b1;
            mem_addr  = a1_ff;
            mem_wdata = sat_acc(32'(v1_ff) + 32'(f1_ff >>> 22));
            state_in  = ST_WC;
         end
         ST_WC: begin
            // Clearing last also zeroes a tap that coincides with this word.
            mem_we    = 1'b1;
            mem_addr  = ac_ff;
            mem_wdata = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         red_ff       <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         red_ff       <= red_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      ch_ff       <= ch_in;
      frame_ff    <= frame_in;
      phase_ff    <= phase_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      u_ff        <= u_in;
      a0_ff       <= a0_in;
      a1_ff       <= a1_in;
      ac_ff       <= ac_in;
      i0_ff       <= i0_in;
      i1_ff       <= i1_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      tap_ff      <= tap_in;
      pd_ff       <= pd_in;
      pw_ff       <= pw_in;
      pf_ff       <= pf_in;
      f0_ff       <= f0_in;
      f1_ff       <= f1_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Ring memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= delay_mem[mem_addr];
   end

   assign clear_done = state_ff != ST_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Samples are taken only after the clearing pass.
   a_pop_after_clear: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> clear_done)
      else $error("sample taken during ring clear");

   // The tap offset is reduced below the ring length before addressing.
   a_tap_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> (RED_W'(red_ff) < RED_W'(RING_FRAMES)))
      else $error("tap offset not reduced");

   // A new result is loaded only from the mix step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_MIX))
      else $error("result loaded outside mix step");

endmodule

[src/modulated_feedback_delay.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay
// Modulated delay line with feedback on interleaved Q1.15 samples.
// ----------------------------------------------------------------------------
// Requests are queued; the back end finishes one sample before it takes the
// next, and computes the LFO taps in addition on a frame's first channel. Its
// pace is set by the serial ring memory port and the shared multiplier of the
// tap unit.
// Reset: synchronous; afterwards the ring is cleared word by word, during
// which no request is accepted.
module modulated_feedback_delay #(
   parameter int unsigned RING_FRAMES     = mfd_pkg::DEF_RING_FRAMES,
   parameter int unsigned MAX_CHANNELS    = mfd_pkg::DEF_MAX_CHANNELS,
   parameter int unsigned SINE_TABLE_BITS = mfd_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mfd_pkg::SAMPLE_W-1:0]     req_tdata,   // in_sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mfd_pkg::SAMPLE_W-1:0]     rsp_tdata,   // out_sample
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mfd_pkg::*;

   localparam int unsigned FRAME_W = $clog2(RING_FRAMES);
   localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned ITEM_W  = 32 + 1 + FRAME_W + CH_W + SAMPLE_W;

   cfg_type           cfg_ff, cfg_in;
   logic              clear_done;
   logic              queue_ready, queue_push, item_valid, item_pop;
   logic [ITEM_W-1:0] queue_item, item;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DRY_GAIN:   cfg_in.dry_gain        = csr_data[15:0];
            REG_WET_GAIN:   cfg_in.wet_gain        = csr_data[15:0];
            REG_FB_GAIN:    cfg_in.feedback_gain   = csr_data[15:0];
            REG_BASE_DELAY: cfg_in.base_delay      = csr_data[19:0];
            REG_MOD_DEPTH:  cfg_in.mod_depth       = csr_data[19:0];
            REG_LFO_STEP:   cfg_in.lfo_step        = csr_data;
            REG_CHANNELS:   cfg_in.active_channels = csr_data[3:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_gain        <= 16'd16384;
         cfg_ff.wet_gain        <= 16'd8192;
         cfg_ff.feedback_gain   <= 16'd8192;
         cfg_ff.base_delay      <= 20'd65536;
         cfg_ff.mod_depth       <= 20'd0;
         cfg_ff.lfo_step        <= 32'd0;
         cfg_ff.active_channels <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfd_front #(
      .RING_FRAMES  (RING_FRAMES),
      .MAX_CHANNELS (MAX_CHANNELS),
      .ITEM_W       (ITEM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clear_done  (clear_done),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_item  (queue_item)
   );

   mfd_queue #(
      .ITEM_W (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_item  (queue_item),
      .push_ready (queue_ready),
      .pop        (item_pop),
      .pop_valid  (item_valid),
      .pop_item   (item)
   );

   mfd_back #(
      .RING_FRAMES     (RING_FRAMES),
      .MAX_CHANNELS    (MAX_CHANNELS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .ITEM_W          (ITEM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clear_done (clear_done),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[sim/modulated_feedback_delay_tb.sv]
// ----------------------------------------------------------------------------
// Modulated feedback delay testbench
// Streams interleaved samples through the delay under several register
// settings, predicts every output sample with a bit-exact model of the ring,
// LFO and mix, and compares each result in order.
// ----------------------------------------------------------------------------
module modulated_feedback_delay_tb;
   import mfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = 4096;
   localparam int CHANS = 2;
   localparam int SBITS = 10;
   localparam longint CYCLE_LIMIT = 4000000;

   // Delay model with its own ring, LFO and register copy.
   class delay_scoreboard;
      int ring_mem[RING*CHANS];
      int unsigned frame_pos, chan_idx, tap_n, tap_f;
      bit [31:0] phase;
      cfg_type cfg;
      logic [15:0] pending[$];
      int errors;
      int checked;

      function void clear();
         foreach (ring_mem[i]) ring_mem[i] = 0;
         frame_pos = 0; chan_idx = 0; phase = 0; tap_n = 0; tap_f = 0;
         cfg.dry_gain = 16384; cfg.wet_gain = 8192; cfg.feedback_gain = 8192;
         cfg.base_delay = 65536; cfg.mod_depth = 0; cfg.lfo_step = 0;
         cfg.active_channels = 2;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_DRY_GAIN:   cfg.dry_gain = val[15:0];
            REG_WET_GAIN:   cfg.wet_gain = val[15:0];
            REG_FB_GAIN:    cfg.feedback_gain = val[15:0];
            REG_BASE_DELAY: cfg.base_delay = val[19:0];
            REG_MOD_DEPTH:  cfg.mod_depth = val[19:0];
            REG_LFO_STEP:   cfg.lfo_step = val;
            REG_CHANNELS:   cfg.active_channels = val[3:0];
            default: ;
         endcase
      endfunction

      // Arithmetic shift right floors toward minus infinity.
      function longint flr(longint v, int s);
         return v >>> s;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint sine_cube(bit [31:0] ph);
         longint k, quad, p, x, x2, t, s, s3;
         k = ph >> (32 - SBITS);
         quad = k >> (SBITS - 2);
         p = k & ((1 << (SBITS - 2)) - 1);
         x = p << (15 - (SBITS - 2));
         if (quad & 1) x = 32768 - x;
         x2 = (x * x) >> 15;
         t = (2320 * x2) >> 15;
         t = 21024 - t;
         t = (x2 * t) >> 15;
         t = 51472 - t;
         s = (x * t) >> 15;
         s3 = (((s * s) >> 15) * s) >> 15;
         return (quad & 2) ? -s3 : s3;
      endfunction

      function void next_frame();
         chan_idx = 0;
         frame_pos = (frame_pos + 1) % RING;
         phase += cfg.lfo_step;
      endfunction

      function void add_to(int addr, longint v);
         ring_mem[addr] = int'(clamp(longint'(ring_mem[addr]) + v, -8388608, 8388607));
      endfunction

      // Notes one accepted request and queues the output it must produce.
      function void note_sample(logic [15:0] raw);
         int unsigned nch, fa, fb, a0, a1, ac;
         longint x, w0, w1, tap0, y, fbv, m, d;
         nch = cfg.active_channels;
         if (nch < 1) nch = 1;
         if (nch > CHANS) nch = CHANS;
         x = longint'($signed(raw));
         if (chan_idx >= nch) next_frame();
         if (chan_idx == 0) begin
            m = (longint'(cfg.mod_depth) * (32768 + sine_cube(phase))) >> 16;
            d = longint'(cfg.base_delay) + m;
            tap_n = (d >> 8) % RING;
            tap_f = d & 255;
         end
         fa = (frame_pos + tap_n) % RING;
         fb = (fa + 1) % RING;
         a0 = fa * CHANS + chan_idx;
         a1 = fb * CHANS + chan_idx;
         ac = frame_pos * CHANS + chan_idx;
         w1 = tap_f;
         w0 = 256 - w1;
         add_to(a0, flr(x * w0, 8));
         add_to(a1, flr(x * w1, 8));
         tap0 = ring_mem[ac];
         y = flr(x * cfg.dry_gain + tap0 * cfg.wet_gain, 14);
         y = clamp(y, -32768, 32767);
         pending.push_back(y[15:0]);
         fbv = tap0 * cfg.feedback_gain;
         add_to(a0, flr(fbv * w0, 22));
         add_to(a1, flr(fbv * w1, 22));
         ring_mem[ac] = 0;
         chan_idx++;
         if (chan_idx >= nch) next_frame();
      endfunction

      function void check_sample(logic [15:0] got);
         logic [15:0] want;
         if (pending.size() == 0) begin
            $error("out_sample: no result expected, actual %0d", $signed(got));
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got !== want) begin
            $error("out_sample: expected %0d, actual %0d", $signed(want), $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [15:0] req_tdata = '0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [15:0] rsp_tdata;

   delay_scoreboard board;
   bit calm_mode = 0;
   int sender_burst_pct = 25;
   longint cycle_count = 0;

   modulated_feedback_delay dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial board = new();

   // Result side: sample at the rising edge, change ready at the falling edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) board.check_sample(rsp_tdata);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("modulated_feedback_delay verification failed");
         $finish;
      end
   end

   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (!calm_mode && $urandom_range(0, 99) < 20) begin
            stall = $urandom_range(1, 8);
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // Sends one request, with an optional idle burst ahead of it. Valid stays
   // up between requests; drain lowers it.
   task automatic send_sample(logic [15:0] s);
      csr_valid <= 0;
      if (!calm_mode && $urandom_range(0, 99) < sender_burst_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(s);
      @(negedge clock);
   endtask

   // Writes one register; the next request lowers the write valid.
   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
   endtask

   // Waits for every expected result, then lets the pipeline settle.
   task automatic drain();
      req_tvalid <= 0;
      csr_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Random sample biased toward the full-scale extremes.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_random(int count);
      repeat (count) send_sample(pick_sample());
   endtask

   initial begin
      logic [15:0] directed[] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                                  16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF, 16'h8000};
      repeat (5) @(negedge clock);
      reset <= 0;
      board.clear();

      // Directed: reset settings, then extremes with a short delay and heavy
      // feedback so the taps accumulate to saturation.
      foreach (directed[i]) send_sample(directed[i]);
      drain();
      write_csr(REG_DRY_GAIN, 32'hFFFF);
      write_csr(REG_WET_GAIN, 32'hFFFF);
      write_csr(REG_FB_GAIN, 32'hFFFF);
      write_csr(REG_BASE_DELAY, 32'h00100);     // one frame
      write_csr(REG_MOD_DEPTH, 32'h0);
      write_csr(REG_CHANNELS, 32'd2);
      repeat (8) send_sample(16'h7FFF);
      repeat (4) send_sample(16'h8000);
      drain();

      // Whole part zero: the tap is the current word itself.
      write_csr(REG_BASE_DELAY, 32'h00080);
      write_csr(REG_DRY_GAIN, 32'd0);
      repeat (4) send_sample(pick_sample());
      drain();

      // Lowering the channel count mid-frame closes the frame early.
      write_csr(REG_CHANNELS, 32'd2);
      send_sample(16'h1234);
      drain();
      write_csr(REG_CHANNELS, 32'd1);
      repeat (3) send_sample(pick_sample());
      drain();

      // Random phases over several settings, out-of-range counts included.
      write_csr(REG_DRY_GAIN, 32'd16384);
      write_csr(REG_WET_GAIN, 32'd12000);
      write_csr(REG_FB_GAIN, 32'd10000);
      write_csr(REG_BASE_DELAY, 32'h00380);
      write_csr(REG_MOD_DEPTH, 32'h00400);
      write_csr(REG_LFO_STEP, 32'h0800_0000);
      write_csr(REG_CHANNELS, 32'd0);
      run_random(110);
      drain();

      // Delay longer than the ring wraps around; full-scale modulation.
      write_csr(REG_BASE_DELAY, 32'hFFC00);
      write_csr(REG_MOD_DEPTH, 32'hFFC00);
      write_csr(REG_LFO_STEP, 32'hFFFF_FFFF);
      write_csr(REG_CHANNELS, 32'd15);
      write_csr(REG_FB_GAIN, 32'd0);
      run_random(110);
      drain();

      write_csr(REG_BASE_DELAY, 32'h00100);
      write_csr(REG_MOD_DEPTH, 32'h00300);
      write_csr(REG_LFO_STEP, $urandom);
      write_csr(REG_CHANNELS, 32'd2);
      write_csr(REG_WET_GAIN, 32'd0);
      write_csr(REG_FB_GAIN, 32'd30000);
      run_random(110);
      // Sender holds off until every expected result has come back.
      drain();
      write_csr(REG_WET_GAIN, $urandom_range(0, 65535));
      write_csr(REG_DRY_GAIN, $urandom_range(0, 65535));
      write_csr(REG_FB_GAIN, $urandom_range(0, 65535));
      write_csr(REG_LFO_STEP, $urandom);
      write_csr(REG_BASE_DELAY, $urandom_range(256, 4096));
      write_csr(REG_MOD_DEPTH, $urandom_range(0, 2048));
      sender_burst_pct = 5;
      run_random(110);
      drain();

      // Final stretch without idling on either side.
      calm_mode = 1;
      write_csr(REG_CHANNELS, 32'd1);
      run_random(110);
      drain();

      $display("Covered %0d output samples across gain, delay, wrap, modulation",
               board.checked);
      $display("and channel-count settings with random stalls on both sides.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("modulated_feedback_delay verification clean");
      end else begin
         $display("modulated_feedback_delay verification failed");
      end
      $finish;
   end
endmodule
